>>> src/m64b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m64b_pkg
// Shared types and constants of the two-lane 64-bit Murmur stream hasher.
// ----------------------------------------------------------------------------
package m64b_pkg;

    localparam logic [31:0] MIX_MUL    = 32'h5bd1_e995;
    localparam logic [31:0] SEED_RESET = 32'hEE6B_27EB;

    // register byte address
    localparam logic [0:0] ADDR_HASH_SEED = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_LANE,
        ST_TAIL,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_FIN4,
        ST_OUT
    } t_ctl_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MIX1,
        OP_MIX2,
        OP_LANE,
        OP_TAIL,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_FIN4
    } t_dp_op;

    typedef struct packed {
        logic   load;      // capture input beat, start message if idle
        t_dp_op op;        // multiplier step
        logic   out_load;  // move lanes into the hash output register
    } t_dp_cmd;

    typedef struct packed {
        logic in_full;     // input beat carries a full word
        logic in_tail;     // input beat carries 1 to 3 bytes
        logic in_last;     // input beat ends the message
        logic item_last;   // captured beat ends the message
    } t_dp_status;

endpackage

>>> src/m64b_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m64b_datapath
// Lane registers, seed register and the shared 32x32 multiplier by MIX_MUL.
// ----------------------------------------------------------------------------
module m64b_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_valid_bytes,
    input  logic                 i_last_item,
    input  logic [30:0]          i_message_length,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    output logic [31:0]          o_seed,
    input  m64b_pkg::t_dp_cmd    i_cmd,
    output m64b_pkg::t_dp_status o_status,
    output logic [63:0]          o_hash_value
);
    import m64b_pkg::*;

    logic [31:0] r_lane_one;
    logic [31:0] r_lane_two;
    logic        r_next_two;
    logic        r_mid;
    logic [31:0] r_seed;
    logic [31:0] r_k;
    logic [1:0]  r_nbytes;
    logic        r_last;
    logic [63:0] r_hash;

    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] tail_mask;

    always_comb begin
        unique case (r_nbytes)
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_MIX1: mul_a = r_k;
            OP_MIX2: mul_a = r_k ^ (r_k >> 24);
            OP_LANE: mul_a = r_next_two ? r_lane_two : r_lane_one;
            OP_TAIL: mul_a = r_lane_two ^ (r_k & tail_mask);
            OP_FIN1: mul_a = r_lane_one ^ (r_lane_two >> 18);
            OP_FIN2: mul_a = r_lane_two ^ (r_lane_one >> 22);
            OP_FIN3: mul_a = r_lane_one ^ (r_lane_two >> 17);
            OP_FIN4: mul_a = r_lane_two ^ (r_lane_one >> 19);
            default: mul_a = r_k;
        endcase
    end

    assign prod = mul_a * MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_one <= '0;
            r_lane_two <= '0;
            r_next_two <= 1'b0;
            r_mid      <= 1'b0;
            r_seed     <= SEED_RESET;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_mid <= !i_last_item;
                if (!r_mid) begin
                    r_lane_one <= r_seed ^ {1'b0, i_message_length};
                    r_lane_two <= '0;
                    r_next_two <= 1'b0;
                end
            end
            unique case (i_cmd.op)
                OP_LANE: begin
                    if (r_next_two) begin
                        r_lane_two <= prod ^ r_k;
                    end else begin
                        r_lane_one <= prod ^ r_k;
                    end
                    r_next_two <= !r_next_two;
                end
                OP_TAIL, OP_FIN2, OP_FIN4: r_lane_two <= prod;
                OP_FIN1, OP_FIN3:          r_lane_one <= prod;
                default: ;
            endcase
        end
    end

    // captured beat, mixed word and hash output register; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k      <= i_data_word;
            r_nbytes <= i_valid_bytes[1:0];
            r_last   <= i_last_item;
        end else if (i_cmd.op == OP_MIX1 || i_cmd.op == OP_MIX2) begin
            r_k <= prod;
        end
        if (i_cmd.out_load) begin
            r_hash <= {r_lane_one, r_lane_two};
        end
    end

    assign o_status.in_full   = i_valid_bytes[2];
    assign o_status.in_tail   = !i_valid_bytes[2] && (i_valid_bytes[1:0] != 2'd0);
    assign o_status.in_last   = i_last_item;
    assign o_status.item_last = r_last;

    assign o_seed       = r_seed;
    assign o_hash_value = r_hash;

endmodule

>>> src/m64b_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m64b_controller
// Sequences the multiplier steps of one beat and owns the output valid flag.
// ----------------------------------------------------------------------------
module m64b_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  m64b_pkg::t_dp_status i_status,
    output m64b_pkg::t_dp_cmd    o_cmd
);
    import m64b_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_status.in_full) n_state = ST_MIX1;
                    else if (i_status.in_tail)    n_state = ST_TAIL;
                    else if (i_status.in_last)    n_state = ST_FIN1;
                    else                          n_state = ST_IDLE;
                end
            end
            ST_MIX1: n_state = ST_MIX2;
            ST_MIX2: n_state = ST_LANE;
            ST_LANE, ST_TAIL: n_state = i_status.item_last ? ST_FIN1 : ST_IDLE;
            ST_FIN1: n_state = ST_FIN2;
            ST_FIN2: n_state = ST_FIN3;
            ST_FIN3: n_state = ST_FIN4;
            ST_FIN4: n_state = ST_OUT;
            ST_OUT:  n_state = out_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load     = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_cmd.load = i_in_valid;
            ST_MIX1: o_cmd.op = OP_MIX1;
            ST_MIX2: o_cmd.op = OP_MIX2;
            ST_LANE: o_cmd.op = OP_LANE;
            ST_TAIL: o_cmd.op = OP_TAIL;
            ST_FIN1: o_cmd.op = OP_FIN1;
            ST_FIN2: o_cmd.op = OP_FIN2;
            ST_FIN3: o_cmd.op = OP_FIN3;
            ST_FIN4: o_cmd.op = OP_FIN4;
            ST_OUT:  o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/murmur64b_hash_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur64b_hash_stream
// Two-lane 64-bit Murmur hash over a stream of little-endian 32-bit words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       i_in_valid / o_in_stall data_word, valid_bytes,
//                                               last_item, message_length
//  out       source     o_out_valid/i_out_stall hash_value
//  cfg       APB slave  psel/penable/pready     hash_seed at address 0
//
//  One 32x32 multiplier is shared by all steps, one step per cycle.
//  A full word runs MIX1, MIX2 and LANE, a 1-3 byte tail runs TAIL, an empty
//  beat only loads; a last beat adds FIN1 to FIN4 and the output load in OUT.
//  The output register lets the next message start while a hash waits;
//  a second hash waits in the load state until the first is taken.
//  Synchronous active-low reset clears lanes, control and sets the seed.
// ----------------------------------------------------------------------------
module murmur64b_hash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_item,
    input  logic [30:0] i_message_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import m64b_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_we;
    logic [31:0] seed;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_HASH_SEED);
    assign prdata = (paddr == ADDR_HASH_SEED) ? seed : 32'h0;

    m64b_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    m64b_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_last_item      (i_last_item),
        .i_message_length (i_message_length),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (pwdata),
        .o_seed           (seed),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_hash_value     (o_hash_value)
    );

endmodule

>>> src/m64b_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m64b_checker
// Port-level checks of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module m64b_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_valid_bytes,
    input logic        i_last_item,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_hash_value
);

    // stalled hash beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hash_value))
        else $error("hash beat changed under stall");

    // a full non-last word occupies the multiplier for three steps
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_valid_bytes[2] && !i_last_item
        |=> o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 !o_in_stall)
        else $error("full word beat did not take three steps");

    // an empty non-last beat is absorbed at once
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_valid_bytes == 3'd0) && !i_last_item
        |=> !o_in_stall)
        else $error("empty beat stalled input");

    // no hash appears without finalization: a new result follows a busy input
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_out_valid) && o_out_valid |-> $past(o_in_stall))
        else $error("hash beat appeared without finalization");

endmodule

bind murmur64b_hash_stream m64b_checker u_m64b_checker (.*);

>>> tb/murmur64b_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur64b_checker
// Watches the input, output and register ports of the hash stream, keeps its
// own two-lane hash state, and compares every accepted hash with the oldest
// predicted one. Reports mismatch and pending counts to the testbench top.
// ----------------------------------------------------------------------------
module murmur64b_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_item,
    input  logic [30:0] i_message_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_hash_value,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_hashes_pending
);
    import m64b_pkg::*;

    logic [63:0] hash_expect_q[$];
    logic [31:0] seed_r;
    logic [31:0] lane_hi;
    logic [31:0] lane_lo;
    logic        word_to_lo;
    logic        in_message;
    int          fails;

    initial begin
        o_fail_count     = 0;
        o_hashes_pending = 0;
        fails            = 0;
    end

    function automatic logic [31:0] mul_m(input logic [31:0] a);
        return a * MIX_MUL;
    endfunction

    // one accepted beat; a last beat finalizes and queues the 64-bit hash
    task automatic absorb_beat(input logic [31:0] word, input logic [2:0] nbytes,
                               input logic last, input logic [30:0] len);
        logic [31:0] k;
        logic [31:0] tail_mask;
        if (!in_message) begin
            lane_hi    = seed_r ^ {1'b0, len};
            lane_lo    = '0;
            word_to_lo = 1'b0;
        end
        if (nbytes[2]) begin
            k = mul_m(word);
            k = k ^ (k >> 24);
            k = mul_m(k);
            if (word_to_lo)
                lane_lo = mul_m(lane_lo) ^ k;
            else
                lane_hi = mul_m(lane_hi) ^ k;
            word_to_lo = ~word_to_lo;
        end else if (nbytes != 3'd0) begin
            case (nbytes)
                3'd1:    tail_mask = 32'h0000_00FF;
                3'd2:    tail_mask = 32'h0000_FFFF;
                default: tail_mask = 32'h00FF_FFFF;
            endcase
            lane_lo = mul_m(lane_lo ^ (word & tail_mask));
        end
        if (!last) begin
            in_message = 1'b1;
        end else begin
            lane_hi = mul_m(lane_hi ^ (lane_lo >> 18));
            lane_lo = mul_m(lane_lo ^ (lane_hi >> 22));
            lane_hi = mul_m(lane_hi ^ (lane_lo >> 17));
            lane_lo = mul_m(lane_lo ^ (lane_hi >> 19));
            hash_expect_q.insert(hash_expect_q.size(), {lane_hi, lane_lo});
            in_message = 1'b0;
            word_to_lo = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            seed_r     = SEED_RESET;
            lane_hi    = '0;
            lane_lo    = '0;
            word_to_lo = 1'b0;
            in_message = 1'b0;
            hash_expect_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_HASH_SEED)
                seed_r = i_pwdata;
            // a beat's own hash cannot leave in the same cycle, so order is free here
            if (i_in_valid && !i_in_stall)
                absorb_beat(i_data_word, i_valid_bytes, i_last_item, i_message_length);
            if (i_out_valid && !i_out_stall) begin
                if (hash_expect_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected hash %h", i_hash_value);
                    fails++;
                end else begin
                    want = hash_expect_q.pop_front();
                    if (want !== i_hash_value) begin
                        if (fails < 10)
                            $display("hash mismatch: expected %h, got %h", want, i_hash_value);
                        fails++;
                    end
                end
            end
        end
        o_fail_count     <= fails;
        o_hashes_pending <= hash_expect_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives messages into the hash stream: a directed set of corner messages at
// the reset seed, then random messages over four seed and flow-control
// phases. The checker beside the block predicts and compares every hash.
// ----------------------------------------------------------------------------
module tb;
    import m64b_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 300;
    localparam int SETTLE      = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_item;
    logic [30:0] message_length;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] hash_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct;
    int stall_pct;
    int items_sent;
    int cycles;
    int fail_count;
    int hashes_pending;

    murmur64b_hash_stream u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_word      (data_word),
        .i_valid_bytes    (valid_bytes),
        .i_last_item      (last_item),
        .i_message_length (message_length),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_hash_value     (hash_value),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    murmur64b_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_data_word      (data_word),
        .i_valid_bytes    (valid_bytes),
        .i_last_item      (last_item),
        .i_message_length (message_length),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_hash_value     (hash_value),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_hashes_pending (hashes_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_length();
        logic [31:0] r;
        r = $urandom;
        return r[30:0];
    endfunction

    // present one beat, then hold it until the block takes it
    task automatic send_beat(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last, input logic [30:0] len);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= word;
        valid_bytes    <= nbytes;
        last_item      <= last;
        message_length <= len;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (nbytes != 3'd0)
            items_sent++;
    endtask

    // mostly well-formed messages; some carry oversized byte counts, stray
    // partial or empty beats, or a declared length that does not match
    task automatic send_message();
        int          n_full;
        int          n_tail;
        bit          noisy;
        bit          end_on_word;
        bit          started;
        logic [30:0] len;
        n_full      = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
        n_tail      = $urandom_range(0, 3);
        noisy       = ($urandom_range(0, 99) < 15);
        end_on_word = (n_tail == 0) && (n_full > 0) && ($urandom_range(0, 3) != 0);
        len         = 31'(n_full * 4 + n_tail);
        started     = 1'b0;
        if ($urandom_range(0, 9) == 0)
            len = pick_length();
        for (int i = 0; i < n_full; i++) begin
            if (noisy && $urandom_range(0, 5) == 0) begin
                send_beat(pick_word(), 3'($urandom_range(0, 3)), 1'b0,
                          started ? pick_length() : len);
                started = 1'b1;
            end
            send_beat(pick_word(),
                      (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'd4,
                      end_on_word && (i == n_full - 1),
                      started ? pick_length() : len);
            started = 1'b1;
        end
        if (!end_on_word)
            send_beat(pick_word(), 3'(n_tail), 1'b1, started ? pick_length() : len);
    endtask

    // no write until every hash is out and the datapath has gone quiet
    task automatic settle();
        do @(posedge clk); while (hashes_pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HASH_SEED;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_word      = '0;
        valid_bytes    = '0;
        last_item      = 1'b0;
        message_length = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = ADDR_HASH_SEED;
        pwdata         = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        items_sent     = 0;
        cycles         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed messages at the reset seed
        send_beat(32'h0000_0000, 3'd0, 1'b1, 31'd0);            // empty message
        send_beat(32'h0000_0000, 3'd4, 1'b1, 31'd4);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b0, 31'd7);            // tail with junk top byte
        send_beat(32'hFFFF_FFFF, 3'd3, 1'b1, 31'h7FFF_FFFF);
        send_beat(32'hFFFF_FFFF, 3'd1, 1'b1, 31'd1);
        send_beat(32'h1234_5678, 3'd2, 1'b1, 31'd2);
        send_beat(32'hA5A5_A5A5, 3'd7, 1'b0, 31'h7FFF_FFFF);    // counts above four
        send_beat(32'h5A5A_5A5A, 3'd5, 1'b0, 31'd0);
        send_beat(32'h8000_0001, 3'd6, 1'b1, 31'd0);
        send_beat(32'hDEAD_BEEF, 3'd2, 1'b0, 31'd0);            // partial word mid-message
        send_beat(32'hCAFE_F00D, 3'd4, 1'b0, 31'd0);
        send_beat(32'h0000_0000, 3'd0, 1'b1, 31'd0);            // empty tail
        send_beat(32'h0123_4567, 3'd4, 1'b0, 31'd8);
        send_beat(32'hFFFF_FFFF, 3'd0, 1'b0, 31'd0);            // empty beat mid-message
        send_beat(32'h89AB_CDEF, 3'd4, 1'b1, 31'd0);
        send_beat(32'h0000_0001, 3'd4, 1'b0, 31'd16);           // lanes alternate
        send_beat(32'h0000_0002, 3'd4, 1'b0, 31'd0);
        send_beat(32'h0000_0003, 3'd4, 1'b0, 31'd0);
        send_beat(32'h8000_0000, 3'd4, 1'b1, 31'd0);
        in_valid <= 1'b0;
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_seed(32'h0000_0000); end
                1: begin idle_pct = 82; stall_pct = 0;  write_seed(32'hFFFF_FFFF); end
                2: begin idle_pct = 0;  stall_pct = 82; write_seed($urandom);      end
                default: begin
                    idle_pct = 24; stall_pct = 24; write_seed($urandom);
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) send_message();
            in_valid <= 1'b0;
            settle();
        end

        if (fail_count == 0 && hashes_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/m64b_pkg.sv
src/m64b_datapath.sv
src/m64b_controller.sv
src/murmur64b_hash_stream.sv
src/m64b_checker.sv
tb/murmur64b_checker.sv
tb/tb.sv
